/* hw/rtl/wsp_pkg.sv */
// Wheel speed period tachometer: shared types, constants and widths.
// Used by the interfaces, the front queue, the back sequencer and the divider.
package wsp_pkg;

  // Moving-average window
  localparam int HIST_DEPTH = 4;
  localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W  = 16 + $clog2(HIST_DEPTH);

  // Field widths
  localparam int CAP_W  = 16;
  localparam int TIME_W = 32;
  localparam int RPM_W  = 16;
  localparam int FREQ_W = 20;
  localparam int PPR_W  = 8;
  localparam int TMO_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FREQ_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd2;
  localparam logic [FREQ_W-1:0] FREQ_RESET    = 20'd100000;
  localparam logic [PPR_W-1:0]  PPR_RESET     = 8'd60;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd150;

  // Speed arithmetic: num = freq * 60, den = avg * ppr
  localparam int RPM_SCALE_W = 6;
  localparam logic [RPM_SCALE_W-1:0] RPM_SCALE = 6'd60;
  localparam int NUM_W = FREQ_W + RPM_SCALE_W;
  localparam int DEN_W = CAP_W + PPR_W;
  localparam int DIV_N = NUM_W + 1;
  localparam int DIV_D = DEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  // Front queue
  localparam int QD = 2;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);

  typedef enum logic {
    ITEM_CAPTURE = 1'b0,
    ITEM_CHECK   = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [CAP_W-1:0]    cap;
    logic [TIME_W-1:0]   now;
  } q_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             rpm_updated;
    logic             timed_out;
    logic [CAP_W-1:0] average_period;
  } out_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [PPR_W-1:0]  ppr;
    logic [TMO_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_N-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_RPM_GO,
    ST_RPM_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

/* hw/rtl/wsp_if.sv */
// Valid/ready channel interfaces for the tachometer input and result items.
// Depends on wsp_pkg for field widths.
interface wsp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [wsp_pkg::CAP_W-1:0]    capture_value;
  logic [wsp_pkg::TIME_W-1:0]   now_ms;
  modport source (output valid, op, capture_value, now_ms, input ready);
  modport sink   (input valid, op, capture_value, now_ms, output ready);
endinterface

interface wsp_out_if;
  logic                      valid;
  logic                      ready;
  logic [wsp_pkg::RPM_W-1:0] rpm;
  logic                      rpm_updated;
  logic                      timed_out;
  logic [wsp_pkg::CAP_W-1:0] average_period;
  modport source (output valid, rpm, rpm_updated, timed_out, average_period, input ready);
  modport sink   (input valid, rpm, rpm_updated, timed_out, average_period, output ready);
endinterface

/* hw/rtl/wsp_front.sv */
// Front end: accepts input items, tags them capture or check, and queues them.
// Depends on wsp_pkg and wsp_in_if.
module wsp_front (
  input  logic              clk,
  input  logic              rst_n,
  wsp_in_if.sink            in_if,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output wsp_pkg::q_item_t  q_item_o
);

  wsp_pkg::q_item_t             entries_r [wsp_pkg::QD];
  logic [wsp_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [wsp_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [wsp_pkg::QCNT_W-1:0]   cnt_r;
  logic                         push;
  logic                         pop;
  wsp_pkg::q_item_t             in_item;

  assign in_if.ready = (cnt_r != wsp_pkg::QCNT_W'(wsp_pkg::QD));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_r != '0);
  assign pop         = q_valid_o && q_ready_i;
  assign q_item_o    = entries_r[rd_ptr_r];

  // Classify the item
  always_comb begin
    in_item.kind = in_if.op ? wsp_pkg::ITEM_CHECK : wsp_pkg::ITEM_CAPTURE;
    in_item.cap  = in_if.capture_value;
    in_item.now  = in_if.now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == wsp_pkg::QPTR_W'(wsp_pkg::QD - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == wsp_pkg::QPTR_W'(wsp_pkg::QD - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/wsp_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Shared by the window average and the speed computation; depends on wsp_pkg.
module wsp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wsp_pkg::div_req_t  req_i,
  output wsp_pkg::div_rsp_t  rsp_o
);

  logic [wsp_pkg::DIV_D-1:0]     rem_r;
  logic [wsp_pkg::DIV_N-1:0]     quo_r;
  logic [wsp_pkg::DIV_D-1:0]     dvs_r;
  logic [wsp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [wsp_pkg::DIV_D:0]       shifted;
  logic [wsp_pkg::DIV_D:0]       diff;
  logic                          fits;

  assign shifted = {rem_r, quo_r[wsp_pkg::DIV_N-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r <= '0;
      quo_r <= req_i.dividend;
      dvs_r <= req_i.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[wsp_pkg::DIV_D-1:0] : shifted[wsp_pkg::DIV_D-1:0];
      quo_r <= {quo_r[wsp_pkg::DIV_N-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == wsp_pkg::DIV_CNT_W'(wsp_pkg::DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/wsp_back.sv */
// Back end: carries out queued items, keeps the period window and speed state,
// and holds the result register. Depends on wsp_pkg and wsp_div.
module wsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wsp_pkg::cfg_t       cfg_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  wsp_pkg::q_item_t    q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsp_pkg::out_item_t  out_item_o
);

  wsp_pkg::back_state_t        state_r, state_nxt;

  logic [wsp_pkg::CAP_W-1:0]   window_r [wsp_pkg::HIST_DEPTH];
  logic [wsp_pkg::CAP_W-1:0]   ref_r;
  logic                        ref_valid_r;
  logic                        rearm_r;
  logic [wsp_pkg::SUM_W-1:0]   sum_r;
  logic [wsp_pkg::SLOT_W-1:0]  slot_r;
  logic [wsp_pkg::FILL_W-1:0]  fill_r;
  logic [wsp_pkg::CAP_W-1:0]   mean_r;
  logic                        fresh_r;
  logic [wsp_pkg::RPM_W-1:0]   speed_r;
  logic [wsp_pkg::TIME_W-1:0]  last_r;
  logic                        upd_r;
  logic                        tmo_r;
  logic [wsp_pkg::NUM_W-1:0]   num_r;
  logic [wsp_pkg::DEN_W-1:0]   den_r;
  logic                        out_valid_r;
  wsp_pkg::out_item_t          out_item_r;

  logic                        take;
  logic                        is_capture;
  logic [wsp_pkg::CAP_W-1:0]   period;
  logic                        win_full;
  logic [wsp_pkg::CAP_W-1:0]   old_period;
  logic [wsp_pkg::SUM_W-1:0]   sum_push;
  logic                        push_cond;
  logic [wsp_pkg::TIME_W-1:0]  elapsed;
  logic                        timeout_cond;
  logic                        out_free;
  logic                        emit_load;
  wsp_pkg::div_req_t           div_req;
  wsp_pkg::div_rsp_t           div_rsp;

  wsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Item classification and window arithmetic
  assign is_capture   = (q_item_i.kind == wsp_pkg::ITEM_CAPTURE);
  assign period       = q_item_i.cap - ref_r;
  assign win_full     = (fill_r == wsp_pkg::FILL_W'(wsp_pkg::HIST_DEPTH));
  assign old_period   = win_full ? window_r[slot_r] : '0;
  assign sum_push     = sum_r - wsp_pkg::SUM_W'(old_period) + wsp_pkg::SUM_W'(period);
  assign push_cond    = !rearm_r && ref_valid_r && (period != '0);
  assign elapsed      = q_item_i.now - last_r;
  assign timeout_cond = (elapsed >= wsp_pkg::TIME_W'(cfg_i.timeout)) && (speed_r != '0);
  assign out_free     = !out_valid_r || out_ready_i;
  assign take         = q_valid_i && q_ready_o;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wsp_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (is_capture) begin
            state_nxt = push_cond ? wsp_pkg::ST_MEAN_GO : wsp_pkg::ST_EMIT;
          end else begin
            state_nxt = fresh_r ? wsp_pkg::ST_RPM_GO : wsp_pkg::ST_EMIT;
          end
        end
      end
      wsp_pkg::ST_MEAN_GO:   state_nxt = wsp_pkg::ST_MEAN_WAIT;
      wsp_pkg::ST_MEAN_WAIT: if (div_rsp.done) state_nxt = wsp_pkg::ST_EMIT;
      wsp_pkg::ST_RPM_GO: begin
        state_nxt = (den_r == '0) ? wsp_pkg::ST_EMIT : wsp_pkg::ST_RPM_WAIT;
      end
      wsp_pkg::ST_RPM_WAIT:  if (div_rsp.done) state_nxt = wsp_pkg::ST_EMIT;
      wsp_pkg::ST_EMIT:      if (out_free) state_nxt = wsp_pkg::ST_IDLE;
      default:               state_nxt = wsp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_ready_o        = 1'b0;
    emit_load        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = wsp_pkg::DIV_N'(num_r) + wsp_pkg::DIV_N'(den_r >> 1);
    div_req.divisor  = den_r;
    case (state_r)
      wsp_pkg::ST_IDLE: q_ready_o = 1'b1;
      wsp_pkg::ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = wsp_pkg::DIV_N'(sum_r);
        div_req.divisor  = wsp_pkg::DIV_D'(fill_r);
      end
      wsp_pkg::ST_RPM_GO: div_req.start = (den_r != '0);
      wsp_pkg::ST_EMIT:   emit_load = out_free;
      default: begin
        q_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Window entries need no reset: each is written before the window reads it
  always_ff @(posedge clk) begin
    if (take && is_capture && push_cond) begin
      window_r[slot_r] <= period;
    end
  end

  // Operands and flags of the item at work
  always_ff @(posedge clk) begin
    if (take) begin
      num_r <= wsp_pkg::NUM_W'(cfg_i.freq) * wsp_pkg::NUM_W'(wsp_pkg::RPM_SCALE);
      den_r <= wsp_pkg::DEN_W'(mean_r) * wsp_pkg::DEN_W'(cfg_i.ppr);
      upd_r <= !is_capture && fresh_r;
      tmo_r <= !is_capture && !fresh_r && timeout_cond;
    end
    if (emit_load) begin
      out_item_r.rpm            <= speed_r;
      out_item_r.rpm_updated    <= upd_r;
      out_item_r.timed_out      <= tmo_r;
      out_item_r.average_period <= mean_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      ref_valid_r <= 1'b0;
      rearm_r     <= 1'b0;
      sum_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      mean_r      <= '0;
      fresh_r     <= 1'b0;
      speed_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (is_capture) begin
          ref_r       <= q_item_i.cap;
          ref_valid_r <= 1'b1;
          if (rearm_r) begin
            // Rearm: restart the window from empty
            rearm_r <= 1'b0;
            sum_r   <= '0;
            slot_r  <= '0;
            fill_r  <= '0;
            mean_r  <= '0;
          end else if (push_cond) begin
            sum_r   <= sum_push;
            slot_r  <= (slot_r == wsp_pkg::SLOT_W'(wsp_pkg::HIST_DEPTH - 1)) ?
                       '0 : slot_r + 1'b1;
            if (!win_full) begin
              fill_r <= fill_r + 1'b1;
            end
            fresh_r <= 1'b1;
          end
        end else if (fresh_r) begin
          fresh_r <= 1'b0;
          last_r  <= q_item_i.now;
        end else if (timeout_cond) begin
          speed_r <= '0;
          rearm_r <= 1'b1;
        end
      end
      if (state_r == wsp_pkg::ST_MEAN_WAIT && div_rsp.done) begin
        mean_r <= div_rsp.quotient[wsp_pkg::CAP_W-1:0];
      end
      if (state_r == wsp_pkg::ST_RPM_GO && den_r == '0) begin
        speed_r <= '0;
      end
      if (state_r == wsp_pkg::ST_RPM_WAIT && div_rsp.done) begin
        // Saturate the quotient to the rpm width
        speed_r <= (|div_rsp.quotient[wsp_pkg::DIV_N-1:wsp_pkg::RPM_W]) ?
                   '1 : div_rsp.quotient[wsp_pkg::RPM_W-1:0];
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_item_o  = out_item_r;

endmodule

/* hw/rtl/wheel_speed_period_tachometer_top.sv */
// Wheel speed period tachometer, top level: configuration registers, front
// queue and back sequencer. Depends on wsp_pkg, wsp_if, wsp_front, wsp_back.
//
// Usage:
//   in_if  : valid/ready channel of items. op=0 carries a timer capture
//            (capture_value), op=1 a periodic speed check (now_ms).
//   out_if : valid/ready channel, exactly one result item per input item,
//            in input order: rpm, rpm_updated, timed_out, average_period.
//   cfg_*  : write port; cfg_index 0 = timer frequency, 1 = pulses per
//            rotation, 2 = zero timeout. Write only while the block is idle.
// Divider use: a capture that adds a period, and a check that recomputes rpm,
//   each pass through the 27-step serial divider (one quotient bit per
//   cycle). A recompute with a zero divisor (average times pulses) skips the
//   divider, as do all other items. Items are worked on one at a time.
// A two-entry queue sits in front of the sequencer, so up to two items are
//   taken while earlier work or a stalled result is pending; the result
//   register holds its item until out_if.ready, and the sequencer waits.
// Reset (rst_n low, synchronous): clear queue, window, speed and reference
//   state; reload the configuration defaults (100000 Hz, 60, 150 ms).
module wheel_speed_period_tachometer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  wsp_in_if.sink                            in_if,
  wsp_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  wsp_pkg::cfg_t      cfg_r;
  logic               q_valid;
  logic               q_ready;
  wsp_pkg::q_item_t   q_item;
  wsp_pkg::out_item_t out_item;

  // Configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq    <= wsp_pkg::FREQ_RESET;
      cfg_r.ppr     <= wsp_pkg::PPR_RESET;
      cfg_r.timeout <= wsp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wsp_pkg::CFG_IDX_FREQ:    cfg_r.freq    <= cfg_wdata[wsp_pkg::FREQ_W-1:0];
        wsp_pkg::CFG_IDX_PPR:     cfg_r.ppr     <= cfg_wdata[wsp_pkg::PPR_W-1:0];
        wsp_pkg::CFG_IDX_TIMEOUT: cfg_r.timeout <= cfg_wdata[wsp_pkg::TMO_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Accept and queue items
  wsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  // Carry out items and hold the result
  wsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_item)
  );

  assign out_if.rpm            = out_item.rpm;
  assign out_if.rpm_updated    = out_item.rpm_updated;
  assign out_if.timed_out      = out_item.timed_out;
  assign out_if.average_period = out_item.average_period;

endmodule

/* hw/rtl/wsp_checker.sv */
// Port-level checks of the tachometer result channel, bound to the top level.
// Depends on wheel_speed_period_tachometer_top and its interface ports.
module wsp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [wsp_pkg::RPM_W-1:0] rpm,
  input logic                      rpm_updated,
  input logic                      timed_out
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A result is either a recompute or a timeout, never both
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(rpm_updated && timed_out))
    else $error("rpm_updated and timed_out both set");

  // A timeout result reports zero speed
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timed_out |-> rpm == '0)
    else $error("timeout with nonzero rpm");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wheel_speed_period_tachometer_top wsp_checker u_wsp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .rpm         (out_if.rpm),
  .rpm_updated (out_if.rpm_updated),
  .timed_out   (out_if.timed_out)
);

/* bench/tb.sv */
// Self-checking bench for wheel_speed_period_tachometer_top: a clocked driver and
// monitor around the block, with an item-level speed predictor kept in this file.
// Depends on wsp_pkg and the wsp_in_if / wsp_out_if channel interfaces.
module tb;
  import wsp_pkg::*;

  // Cycles without any handshake before the run is declared hung, and the
  // idle pause that wait_for_idle takes before a register write.
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wsp_in_if in_ch ();
  wsp_out_if out_ch ();

  wheel_speed_period_tachometer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered, and readings the block still owes us.
  q_item_t pending_events[$];
  out_item_t expected_readings[$];

  int fails = 0;
  int n_captures = 0;
  int n_checks = 0;
  int n_updates = 0;
  int n_timeouts = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;            // when set, neither side idles

  // Shadow copy of the registers.
  logic [FREQ_W-1:0] tick_hz;
  logic [PPR_W-1:0] pulses_per_rev;
  logic [TMO_W-1:0] stale_ms;

  // Shadow copy of the speed state.
  logic [CAP_W-1:0] ref_capture;
  bit ref_valid;
  bit rearm;
  logic [CAP_W-1:0] period_hist[HIST_DEPTH];
  logic [SUM_W-1:0] hist_sum;
  logic [SLOT_W-1:0] hist_slot;
  logic [FILL_W-1:0] hist_fill;
  logic [CAP_W-1:0] mean_ticks;
  bit fresh_mean;
  logic [RPM_W-1:0] speed;
  logic [TIME_W-1:0] last_update_ms;

  // Cursors that keep random traffic well formed: a free-running tick count
  // and a wall clock in ms.
  logic [CAP_W-1:0] tick_cursor = '0;
  logic [TIME_W-1:0] ms_cursor = '0;

  function automatic void clear_window();
    foreach (period_hist[i]) period_hist[i] = '0;
    hist_sum = '0;
    hist_slot = '0;
    hist_fill = '0;
    mean_ticks = '0;
  endfunction

  function automatic void clear_tachometer();
    tick_hz = FREQ_RESET;
    pulses_per_rev = PPR_RESET;
    stale_ms = TIMEOUT_RESET;
    ref_capture = '0;
    ref_valid = 1'b0;
    rearm = 1'b0;
    clear_window();
    fresh_mean = 1'b0;
    speed = '0;
    last_update_ms = '0;
  endfunction

  // rpm = round(freq * 60 / (avg * ppr)), saturated; zero when the divisor is.
  function automatic logic [RPM_W-1:0] rpm_from_period(input logic [CAP_W-1:0] avg);
    longint unsigned den;
    longint unsigned num;
    longint unsigned q;
    den = 64'(avg) * 64'(pulses_per_rev);
    if (den == 0) return '0;
    num = 64'(tick_hz) * 64'd60;
    q = (num + den / 2) / den;
    return (q > 64'hFFFF) ? {RPM_W{1'b1}} : q[RPM_W-1:0];
  endfunction

  function automatic void push_period(input logic [CAP_W-1:0] p);
    if (hist_fill < HIST_DEPTH) hist_fill = hist_fill + 1'b1;
    else hist_sum = hist_sum - SUM_W'(period_hist[hist_slot]);
    period_hist[hist_slot] = p;
    hist_sum = hist_sum + SUM_W'(p);
    hist_slot = (hist_slot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : hist_slot + 1'b1;
    mean_ticks = CAP_W'(hist_sum / hist_fill);
    fresh_mean = 1'b1;
  endfunction

  // Advance the shadow state by one accepted item and return the reading due.
  function automatic out_item_t advance_tachometer(input q_item_t it);
    out_item_t r;
    logic [CAP_W-1:0] p;
    logic [TIME_W-1:0] elapsed;
    r.rpm_updated = 1'b0;
    r.timed_out = 1'b0;
    if (it.kind == ITEM_CAPTURE) begin
      if (rearm) begin
        clear_window();
        ref_capture = it.cap;
        ref_valid = 1'b1;
        rearm = 1'b0;
      end else if (!ref_valid) begin
        ref_capture = it.cap;
        ref_valid = 1'b1;
      end else begin
        p = it.cap - ref_capture;
        ref_capture = it.cap;
        if (p != '0) push_period(p);
      end
    end else begin
      elapsed = it.now - last_update_ms;
      if (fresh_mean) begin
        fresh_mean = 1'b0;
        speed = rpm_from_period(mean_ticks);
        last_update_ms = it.now;
        r.rpm_updated = 1'b1;
      end else if (elapsed >= TIME_W'(stale_ms) && speed != '0) begin
        speed = '0;
        rearm = 1'b1;
        r.timed_out = 1'b1;
      end
    end
    r.rpm = speed;
    r.average_period = mean_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. The field an item does not use gets random bits so that
  // every input bit toggles.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input item_kind_t k, input logic [CAP_W-1:0] c,
                            input logic [TIME_W-1:0] n);
    pending_events.push_back('{kind: k, cap: c, now: n});
  endtask

  task automatic queue_capture(input logic [CAP_W-1:0] c);
    queue_item(ITEM_CAPTURE, c, $urandom);
  endtask

  task automatic queue_check(input logic [TIME_W-1:0] n);
    queue_item(ITEM_CHECK, CAP_W'($urandom), n);
  endtask

  // Hold until the block has answered every item, then let it settle.
  task automatic wait_for_idle();
    while (pending_events.size() != 0 || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_FREQ:    tick_hz = val[FREQ_W-1:0];
      CFG_IDX_PPR:     pulses_per_rev = val[PPR_W-1:0];
      CFG_IDX_TIMEOUT: stale_ms = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly well-formed bursts: a few captures spaced by plausible periods,
  // then one to three checks with the clock moved around the timeout. About
  // one burst in ten is replaced by a single item of pure noise.
  task automatic queue_random_traffic(input int count);
    int made;
    int n_caps;
    int n_chk;
    logic [CAP_W-1:0] step;
    logic [TIME_W-1:0] adv;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 10) begin
        queue_item(item_kind_t'($urandom_range(1)), CAP_W'($urandom), $urandom);
        made++;
      end else begin
        n_caps = $urandom_range(0, 5);
        n_chk = $urandom_range(1, 3);
        repeat (n_caps) begin
          case ($urandom_range(9))
            0: step = '0;
            1: step = CAP_W'($urandom);
            2: step = CAP_W'($urandom_range(1, 4));
            3: step = {CAP_W{1'b1}};
            default: step = CAP_W'($urandom_range(20, 3000));
          endcase
          tick_cursor = tick_cursor + step;
          queue_capture(tick_cursor);
          made++;
        end
        repeat (n_chk) begin
          case ($urandom_range(9))
            0: adv = '0;
            1, 2, 3: adv = $urandom_range(1, 50);
            4: adv = TIME_W'(stale_ms) - 1;
            5: adv = TIME_W'(stale_ms);
            6: adv = TIME_W'(stale_ms) + 1;
            7: adv = $urandom_range(0, 70000);
            8: adv = $urandom;
            default: adv = $urandom_range(50, 400);
          endcase
          ms_cursor = ms_cursor + adv;
          queue_check(ms_cursor);
          made++;
        end
      end
    end
  endtask

  task automatic run_setting(input logic [FREQ_W-1:0] f, input logic [PPR_W-1:0] ppr,
                             input logic [TMO_W-1:0] tmo, input int count);
    wait_for_idle();
    write_setting(CFG_IDX_FREQ, CFG_DATA_W'(f));
    write_setting(CFG_IDX_PPR, CFG_DATA_W'(ppr));
    write_setting(CFG_IDX_TIMEOUT, CFG_DATA_W'(tmo));
    queue_random_traffic(count);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Hold an offered item until it
  // is taken; otherwise offer the next one unless this cycle idles.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!(in_ch.valid && !in_taken)) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        in_ch.valid <= 1'b1;
        in_ch.op <= pending_events[0].kind;
        in_ch.capture_value <= pending_events[0].cap;
        in_ch.now_ms <= pending_events[0].now;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge. Check the reading first,
  // since it always belongs to an item taken on an earlier edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    q_item_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with no item outstanding: rpm %0d", out_ch.rpm);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.rpm !== want.rpm) begin
            $error("rpm: expected %0d, got %0d", want.rpm, out_ch.rpm);
            fails++;
          end
          if (out_ch.rpm_updated !== want.rpm_updated) begin
            $error("rpm_updated: expected %0d, got %0d", want.rpm_updated,
                   out_ch.rpm_updated);
            fails++;
          end
          if (out_ch.timed_out !== want.timed_out) begin
            $error("timed_out: expected %0d, got %0d", want.timed_out, out_ch.timed_out);
            fails++;
          end
          if (out_ch.average_period !== want.average_period) begin
            $error("average_period: expected %0d, got %0d", want.average_period,
                   out_ch.average_period);
            fails++;
          end
          n_updates += want.rpm_updated;
          n_timeouts += want.timed_out;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got.kind = item_kind_t'(in_ch.op);
        got.cap = in_ch.capture_value;
        got.now = in_ch.now_ms;
        if (got.kind == ITEM_CAPTURE) n_captures++;
        else n_checks++;
        expected_readings.push_back(advance_tachometer(got));
        void'(pending_events.pop_front());
      end
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("wheel_speed_period_tachometer_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed walk on the reset settings, then random traffic
  // under a series of register settings, extremes included.
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.capture_value = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    clear_tachometer();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk with 100000 Hz, 60 pulses, 150 ms.
    queue_check(32'd0);               // nothing measured yet
    queue_capture(16'h0000);          // first capture only sets the reference
    queue_capture(16'h0000);          // zero period: dropped
    queue_capture(16'd1000);          // first period, fresh average
    queue_check(32'd10);              // compute rpm
    queue_check(32'd20);              // no new average, well inside timeout
    queue_capture(16'hFFF0);
    queue_capture(16'h0010);          // period across the timer wrap
    queue_capture(16'h000F);          // largest period
    queue_capture(16'h0010);          // smallest period, oldest sample drops
    queue_check(32'hFFFF_FFFF);       // compute rpm at the top of the ms clock
    queue_check(32'h0000_0094);       // one ms short of the timeout, across wrap
    queue_check(32'h0000_0095);       // timeout: zero rpm and rearm
    queue_check(32'h0000_0200);       // rpm already zero: no change
    queue_capture(16'h1234);          // rearm capture clears the window
    queue_capture(16'h123E);
    queue_check(32'h0000_0300);
    queue_capture(16'hFFFF);
    queue_check(32'h8000_0000);

    // Saturating speeds: fastest timer, one pulse per turn, longest timeout.
    run_setting(20'hFFFFF, 8'd1, 16'hFFFF, 80);
    // Slowest timer, most pulses, shortest timeout.
    run_setting(20'd1, 8'd255, 16'd1, 80);
    // Stopped timer and a zero timeout.
    run_setting(20'd0, 8'd7, 16'd0, 50);
    // No pulses per turn.
    run_setting(20'd250000, 8'd0, 16'd1000, 50);
    // Random rates with a zero timeout.
    run_setting(FREQ_W'($urandom_range(1, 1000000)), PPR_W'($urandom_range(1, 255)),
                16'd0, 80);
    // Random settings, both sides always ready.
    wait_for_idle();
    calm = 1'b1;
    run_setting(FREQ_W'($urandom_range(1, 1000000)), PPR_W'($urandom_range(1, 255)),
                TMO_W'($urandom_range(1, 65535)), 80);
    wait_for_idle();
    calm = 1'b0;
    // Back to the reset values, written explicitly.
    run_setting(FREQ_RESET, PPR_RESET, TIMEOUT_RESET, 80);

    wait_for_idle();
    $display("run covered %0d captures and %0d checks over eight register settings,",
             n_captures, n_checks);
    $display("with %0d speed updates and %0d stale-speed timeouts", n_updates, n_timeouts);
    if (fails == 0) begin
      $display("wheel_speed_period_tachometer_top regression: pass");
    end else begin
      $display("wheel_speed_period_tachometer_top regression: fail");
    end
    $finish;
  end

endmodule

/* wheel_speed_period_tachometer_top.f */
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_if.sv
hw/rtl/wsp_front.sv
hw/rtl/wsp_div.sv
hw/rtl/wsp_back.sv
hw/rtl/wheel_speed_period_tachometer_top.sv
hw/rtl/wsp_checker.sv
bench/tb.sv
